FILE: design/swept_box_collision_test_macros.svh
// Assertion macros shared by the checker of the swept box collision test.
// Holds only macro definitions behind an include guard; no other dependencies.
`ifndef SWEPT_BOX_COLLISION_TEST_MACROS_SVH
`define SWEPT_BOX_COLLISION_TEST_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define SBCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked around reset.
`define SBCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/sbct_pkg.sv
// Shared types and constants of the swept box collision test.
// No dependencies; imported by the top level, the segment unit and the checker.
package sbct_pkg;

   // Side of the previous box on which the obstacle lay.
   typedef enum logic [2:0] {
      SIDE_NONE   = 3'd0,
      SIDE_LEFT   = 3'd1,
      SIDE_RIGHT  = 3'd2,
      SIDE_TOP    = 3'd3,
      SIDE_BOTTOM = 3'd4
   } side_type;

   // Result transaction: overlap_now, swept_hit, any_hit, contact_side.
   localparam int RSP_FIELD_BITS = 6;
   localparam int RSP_DATA_BITS  = 8;

   // Load enables of the pipeline stages that live inside the segment units.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

FILE: design/sbct_seg_cross.sv
// One motion segment tested against each edge (top, right, bottom, left) of the obstacle.
// Uses sbct_pkg for the stage enable struct; holds pipeline stages two to four.
module sbct_seg_cross
   import sbct_pkg::*;
#(
   parameter int POINT_BITS = 26
) (
   input  logic                         clock,
   input  stage_en_type                 en,
   input  logic signed [POINT_BITS-1:0] sx,
   input  logic signed [POINT_BITS-1:0] sy,
   input  logic signed [POINT_BITS-1:0] dx,
   input  logic signed [POINT_BITS-1:0] dy,
   input  logic signed [POINT_BITS-1:0] obs_l,
   input  logic signed [POINT_BITS-1:0] obs_r,
   input  logic signed [POINT_BITS-1:0] obs_t,
   input  logic signed [POINT_BITS-1:0] obs_b,
   input  logic                         ow_nz,
   input  logic                         oh_nz,
   output logic                         seg_hit
);

   localparam int DW = POINT_BITS + 1;
   localparam int MW = 2 * DW;
   localparam int CW = MW + 1;

   // Stage two: direction of the segment and offsets to the obstacle lines.
   logic signed [DW-1:0] ux_ff, uy_ff, dl_ff, dr_ff, dt_ff, db_ff;
   logic signed [DW-1:0] ux_in, uy_in, dl_in, dr_in, dt_in, db_in;
   // Edge bits, top, right, bottom, left from bit 0: both endpoints lie
   // strictly on opposite sides of that edge's line.
   logic [3:0] edge2_ff, edge2_in, edge3_ff, edge4_ff;

   // Stage three: the four products that build every corner cross product.
   logic signed [MW-1:0] at_ff, ab_ff, bl_ff, br_ff;

   // Stage four: sign of the segment line at each obstacle corner,
   // top left, top right, bottom right, bottom left from bit 0.
   logic signed [CW-1:0] corner_in [4];
   logic [3:0] pos_ff, neg_ff, pos_in, neg_in;

   always_comb begin
      ux_in = DW'(dx) - DW'(sx);
      uy_in = DW'(dy) - DW'(sy);
      dl_in = DW'(obs_l) - DW'(sx);
      dr_in = DW'(obs_r) - DW'(sx);
      dt_in = DW'(obs_t) - DW'(sy);
      db_in = DW'(obs_b) - DW'(sy);
      edge2_in[0] = ow_nz && ((sy < obs_t && dy > obs_t) || (sy > obs_t && dy < obs_t));
      edge2_in[1] = oh_nz && ((sx < obs_r && dx > obs_r) || (sx > obs_r && dx < obs_r));
      edge2_in[2] = ow_nz && ((sy < obs_b && dy > obs_b) || (sy > obs_b && dy < obs_b));
      edge2_in[3] = oh_nz && ((sx < obs_l && dx > obs_l) || (sx > obs_l && dx < obs_l));
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         dl_ff    <= dl_in;
         dr_ff    <= dr_in;
         dt_ff    <= dt_in;
         db_ff    <= db_in;
         edge2_ff <= edge2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         at_ff    <= MW'(ux_ff) * MW'(dt_ff);
         ab_ff    <= MW'(ux_ff) * MW'(db_ff);
         bl_ff    <= MW'(uy_ff) * MW'(dl_ff);
         br_ff    <= MW'(uy_ff) * MW'(dr_ff);
         edge3_ff <= edge2_ff;
      end
   end

   // The cross product at corner (X, Y) is ux*(Y-sy) - uy*(X-sx).
   always_comb begin
      corner_in[0] = CW'(at_ff) - CW'(bl_ff);
      corner_in[1] = CW'(at_ff) - CW'(br_ff);
      corner_in[2] = CW'(ab_ff) - CW'(br_ff);
      corner_in[3] = CW'(ab_ff) - CW'(bl_ff);
      for (int c = 0; c < 4; c++) begin
         neg_in[c] = corner_in[c][CW-1];
         pos_in[c] = !corner_in[c][CW-1] && (|corner_in[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         edge4_ff <= edge3_ff;
      end
   end

   // Edge e runs from corner e to corner e+1; both corners must lie strictly
   // on opposite sides of the segment line.
   always_comb begin
      seg_hit = 1'b0;
      for (int e = 0; e < 4; e++) begin
         if (edge4_ff[e] &&
             ((pos_ff[e] && neg_ff[(e + 1) % 4]) || (neg_ff[e] && pos_ff[(e + 1) % 4])))
            seg_hit = 1'b1;
      end
   end

endmodule

FILE: design/swept_box_collision_test.sv
// Swept box versus static box collision test, top level; uses sbct_pkg, sbct_seg_cross.
// An accepted request transaction reaches rsp_tvalid through stages one to five.
// Throughput: one transaction per cycle while the output is not stalled; the five register
// stages, with the cross product multipliers alone in stage three, set the latency and clock rate.
// Reset is synchronous and active high; it clears only the stage valid bits.
module swept_box_collision_test
   import sbct_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // From bit 0: prev_left, prev_top, prev_width, prev_height, cur_left, cur_top,
   // cur_width, cur_height, obstacle_left, obstacle_top, obstacle_width,
   // obstacle_height, then zero fill up to whole bytes.
   input  logic [((12 * COORD_BITS - 6 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // From bit 0: overlap_now, swept_hit, any_hit, contact_side[2:0], zero fill.
   output logic [RSP_DATA_BITS-1:0]                     rsp_tdata
);

   // Positions are COORD_BITS wide and signed, sizes are one bit narrower and
   // unsigned. All geometry is carried at PW bits, which holds every edge and
   // every doubled-scale point exactly.
   localparam int W   = COORD_BITS;
   localparam int SZ  = COORD_BITS - 1;
   localparam int PW  = COORD_BITS + 2;
   localparam int GRP = 4 * COORD_BITS - 2;
   localparam int NSEG = 5;

   // Field offsets inside req_tdata for the previous, current and obstacle boxes.
   localparam int OFS_PL = 0;
   localparam int OFS_PT = W;
   localparam int OFS_PW = 2 * W;
   localparam int OFS_PH = 3 * W - 1;
   localparam int OFS_CL = GRP + OFS_PL;
   localparam int OFS_CT = GRP + OFS_PT;
   localparam int OFS_CW = GRP + OFS_PW;
   localparam int OFS_CH = GRP + OFS_PH;
   localparam int OFS_OL = 2 * GRP + OFS_PL;
   localparam int OFS_OT = 2 * GRP + OFS_PT;
   localparam int OFS_OW = 2 * GRP + OFS_PW;
   localparam int OFS_OH = 2 * GRP + OFS_PH;

   // ---------------------------------------------------------------------
   // Pipeline flow control. Each stage loads when it is empty or when the
   // stage after it moves, so bubbles are squeezed out and an item can be
   // accepted while a finished result still waits in the output register.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   stage_en_type seg_en;

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;
   assign seg_en = '{s2: en2, s3: en3, s4: en4};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage one: unpack, extend, form box edges and doubled-scale points.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] pl_x, pt_x, pw_x, ph_x;
   logic signed [PW-1:0] cl_x, ct_x, cw_x, ch_x;
   logic signed [PW-1:0] ol_x, ot_x, ow_x, oh_x;
   logic signed [PW-1:0] p_right, p_bottom, c_right, c_bottom, o_right, o_bottom;

   assign pl_x = PW'($signed(req_tdata[OFS_PL +: W]));
   assign pt_x = PW'($signed(req_tdata[OFS_PT +: W]));
   assign pw_x = PW'(req_tdata[OFS_PW +: SZ]);
   assign ph_x = PW'(req_tdata[OFS_PH +: SZ]);
   assign cl_x = PW'($signed(req_tdata[OFS_CL +: W]));
   assign ct_x = PW'($signed(req_tdata[OFS_CT +: W]));
   assign cw_x = PW'(req_tdata[OFS_CW +: SZ]);
   assign ch_x = PW'(req_tdata[OFS_CH +: SZ]);
   assign ol_x = PW'($signed(req_tdata[OFS_OL +: W]));
   assign ot_x = PW'($signed(req_tdata[OFS_OT +: W]));
   assign ow_x = PW'(req_tdata[OFS_OW +: SZ]);
   assign oh_x = PW'(req_tdata[OFS_OH +: SZ]);

   assign p_right  = pl_x + pw_x;
   assign p_bottom = pt_x + ph_x;
   assign c_right  = cl_x + cw_x;
   assign c_bottom = ct_x + ch_x;
   assign o_right  = ol_x + ow_x;
   assign o_bottom = ot_x + oh_x;

   // Strict overlap of the current box with the obstacle: touching edges miss.
   logic overlap_in;
   assign overlap_in = !(ol_x >= c_right || o_right <= cl_x ||
                         ot_x >= c_bottom || o_bottom <= ct_x);

   // Side of the previous box on which the obstacle lay. An obstacle that is
   // strictly beyond the previous box in both axes at once reports no side;
   // otherwise the first matching side wins in the order left, right, top,
   // bottom.
   side_type side_in;
   logic     diag_sep;

   always_comb begin
      diag_sep = (ol_x > p_right && ot_x > p_bottom) ||
                 (o_right < pl_x && ot_x > p_bottom) ||
                 (o_right < pl_x && o_bottom < pt_x) ||
                 (ol_x > p_right && o_bottom < pt_x);
      priority if (diag_sep)            side_in = SIDE_NONE;
      else if (o_right <= pl_x)         side_in = SIDE_LEFT;
      else if (ol_x >= p_right)         side_in = SIDE_RIGHT;
      else if (o_bottom <= pt_x)        side_in = SIDE_TOP;
      else if (ot_x >= p_bottom)        side_in = SIDE_BOTTOM;
      else                              side_in = SIDE_NONE;
   end

   // Segment endpoints at doubled scale: the centre first, then the corners
   // top left, top right, bottom right and bottom left. The previous corners
   // use the previous size and the current corners the current size.
   logic signed [PW-1:0] sx_in [NSEG];
   logic signed [PW-1:0] sy_in [NSEG];
   logic signed [PW-1:0] dx_in [NSEG];
   logic signed [PW-1:0] dy_in [NSEG];
   logic signed [PW-1:0] pl2, pt2, pw2, ph2, cl2, ct2, cw2, ch2;

   always_comb begin
      pl2 = pl_x <<< 1;
      pt2 = pt_x <<< 1;
      pw2 = pw_x <<< 1;
      ph2 = ph_x <<< 1;
      cl2 = cl_x <<< 1;
      ct2 = ct_x <<< 1;
      cw2 = cw_x <<< 1;
      ch2 = ch_x <<< 1;
      sx_in[0] = pl2 + pw_x;   sy_in[0] = pt2 + ph_x;
      sx_in[1] = pl2;          sy_in[1] = pt2;
      sx_in[2] = pl2 + pw2;    sy_in[2] = pt2;
      sx_in[3] = pl2 + pw2;    sy_in[3] = pt2 + ph2;
      sx_in[4] = pl2;          sy_in[4] = pt2 + ph2;
      dx_in[0] = cl2 + cw_x;   dy_in[0] = ct2 + ch_x;
      dx_in[1] = cl2;          dy_in[1] = ct2;
      dx_in[2] = cl2 + cw2;    dy_in[2] = ct2;
      dx_in[3] = cl2 + cw2;    dy_in[3] = ct2 + ch2;
      dx_in[4] = cl2;          dy_in[4] = ct2 + ch2;
   end

   logic signed [PW-1:0] sx_ff [NSEG];
   logic signed [PW-1:0] sy_ff [NSEG];
   logic signed [PW-1:0] dx_ff [NSEG];
   logic signed [PW-1:0] dy_ff [NSEG];
   logic signed [PW-1:0] obs_l_ff, obs_r_ff, obs_t_ff, obs_b_ff;
   logic                 ow_nz_ff, oh_nz_ff;
   logic                 overlap1_ff, overlap2_ff, overlap3_ff, overlap4_ff;
   side_type             side1_ff, side2_ff, side3_ff, side4_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int k = 0; k < NSEG; k++) begin
            sx_ff[k] <= sx_in[k];
            sy_ff[k] <= sy_in[k];
            dx_ff[k] <= dx_in[k];
            dy_ff[k] <= dy_in[k];
         end
         obs_l_ff    <= ol_x <<< 1;
         obs_r_ff    <= o_right <<< 1;
         obs_t_ff    <= ot_x <<< 1;
         obs_b_ff    <= o_bottom <<< 1;
         ow_nz_ff    <= |ow_x;
         oh_nz_ff    <= |oh_x;
         overlap1_ff <= overlap_in;
         side1_ff    <= side_in;
      end
   end

   // The overlap flag and the side code ride along while the segments are
   // being tested.
   always_ff @(posedge clock) begin
      if (en2) begin
         overlap2_ff <= overlap1_ff;
         side2_ff    <= side1_ff;
      end
      if (en3) begin
         overlap3_ff <= overlap2_ff;
         side3_ff    <= side2_ff;
      end
      if (en4) begin
         overlap4_ff <= overlap3_ff;
         side4_ff    <= side3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stages two to four: one crossing unit per motion segment.
   // ---------------------------------------------------------------------
   logic [NSEG-1:0] seg_hit;

   for (genvar k = 0; k < NSEG; k++) begin : g_seg
      sbct_seg_cross #(
         .POINT_BITS(PW)
      ) u_seg (
         .clock   (clock),
         .en      (seg_en),
         .sx      (sx_ff[k]),
         .sy      (sy_ff[k]),
         .dx      (dx_ff[k]),
         .dy      (dy_ff[k]),
         .obs_l   (obs_l_ff),
         .obs_r   (obs_r_ff),
         .obs_t   (obs_t_ff),
         .obs_b   (obs_b_ff),
         .ow_nz   (ow_nz_ff),
         .oh_nz   (oh_nz_ff),
         .seg_hit (seg_hit[k])
      );
   end

   // ---------------------------------------------------------------------
   // Stage five: the output register, held while the consumer stalls.
   // ---------------------------------------------------------------------
   logic     overlap5_ff, swept5_ff;
   side_type side5_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         overlap5_ff <= overlap4_ff;
         swept5_ff   <= |seg_hit;
         side5_ff    <= side4_ff;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}}, side5_ff,
                        overlap5_ff | swept5_ff, swept5_ff, overlap5_ff};

endmodule

FILE: design/sbct_checker.sv
// Port-level checker of the swept box collision test, bound to the top level.
// Uses sbct_pkg and the assertion macros in swept_box_collision_test_macros.svh.
`include "swept_box_collision_test_macros.svh"

module sbct_checker
   import sbct_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // A result that is not taken stays offered with the same data.
   `SBCT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp transaction dropped or changed while stalled")

   // With the consumer ready throughout, an accepted request shows up as a result on rsp_tvalid.
   `SBCT_ASSERT(a_latency, clock, reset, (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready |-> ##1 rsp_tvalid, "result missing after pipeline latency")

   // any_hit is the union of the two hit flags and the side code is legal.
   `SBCT_ASSERT(a_rsp_fields, clock, reset, rsp_tvalid |-> (rsp_tdata[2] == (rsp_tdata[0] | rsp_tdata[1])) && (rsp_tdata[5:3] <= SIDE_BOTTOM), "inconsistent result fields")

   // Reset leaves no result behind.
   `SBCT_ASSERT_ALWAYS(a_reset_empty, clock, $fell(reset) |-> !rsp_tvalid, "result valid right after reset")

endmodule

bind swept_box_collision_test sbct_checker u_sbct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
